// ----- rtl/core/midpoint_circle_generator_macros.svh -----
// Assertion macros shared by the circle generator modules.
// Each use expects clk and rst_n in scope.
`ifndef MIDPOINT_CIRCLE_GENERATOR_MACROS_SVH
`define MIDPOINT_CIRCLE_GENERATOR_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define MCG_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mcg assertion failed");

// next-cycle implication
`define MCG_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mcg assertion failed");

`else

`define MCG_ASSERT_IMP(lbl, ante, cons)
`define MCG_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

// ----- rtl/core/mcg_pkg.sv -----
package mcg_pkg;

  localparam int SCREEN_WIDTH  = 96;   // 1..256
  localparam int SCREEN_HEIGHT = 64;   // 1..256
  localparam int MAX_RADIUS    = 63;   // 1..63
  localparam int RESULT_CAP    = 64;

  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_AW    = 1;

  localparam int D_W     = 12;  // decision value, signed
  localparam int COORD_W = 10;  // pixel coordinate, signed

  typedef struct packed {
    logic [7:0]  center_x;
    logic [7:0]  center_y;
    logic [5:0]  radius;
    logic [15:0] color;
  } req_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } back_state_t;

  function automatic logic on_screen(input logic signed [COORD_W-1:0] px,
                                     input logic signed [COORD_W-1:0] py);
    // non-negative first, then compare magnitude against the screen size
    return !px[COORD_W-1] && !py[COORD_W-1] &&
           (px[COORD_W-2:0] < (COORD_W-1)'(SCREEN_WIDTH)) &&
           (py[COORD_W-2:0] < (COORD_W-1)'(SCREEN_HEIGHT));
  endfunction

  function automatic logic [7:0] octant_mask(input logic [7:0] cx,
                                             input logic [7:0] cy,
                                             input logic [5:0] a,
                                             input logic [5:0] b);
    logic signed [COORD_W-1:0] x, y, sa, sb;
    logic [7:0] m;
    x  = $signed({2'b00, cx});
    y  = $signed({2'b00, cy});
    sa = $signed({4'b0000, a});
    sb = $signed({4'b0000, b});
    m[0] = on_screen(x + sa, y + sb);
    m[1] = on_screen(x + sa, y - sb);
    m[2] = on_screen(x - sa, y + sb);
    m[3] = on_screen(x - sa, y - sb);
    m[4] = on_screen(x + sb, y + sa);
    m[5] = on_screen(x + sb, y - sa);
    m[6] = on_screen(x - sb, y + sa);
    m[7] = on_screen(x - sb, y - sa);
    return m;
  endfunction

endpackage

// ----- rtl/core/mcg_front.sv -----
module mcg_front
  import mcg_pkg::*;
(
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_center_x,
  input  logic [7:0]  in_center_y,
  input  logic [5:0]  in_radius,
  input  logic [15:0] in_color,
  input  logic        fifo_full,
  output logic        push,
  output req_t        push_req
);

  logic center_ok;
  logic [5:0] radius_clamped;

  assign center_ok = ({1'b0, in_center_x} < 9'(SCREEN_WIDTH)) &&
                     ({1'b0, in_center_y} < 9'(SCREEN_HEIGHT));

  assign radius_clamped = ({1'b0, in_radius} > 7'(MAX_RADIUS)) ? 6'(MAX_RADIUS) : in_radius;

  // off-screen centers are taken and dropped
  assign in_ready = !fifo_full;
  assign push     = in_valid && in_ready && center_ok;

  assign push_req.center_x = in_center_x;
  assign push_req.center_y = in_center_y;
  assign push_req.radius   = radius_clamped;
  assign push_req.color    = in_color;

endmodule

// ----- rtl/core/mcg_fifo.sv -----
`include "midpoint_circle_generator_macros.svh"

module mcg_fifo
  import mcg_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  req_t push_req,
  input  logic pop,
  output req_t head,
  output logic empty,
  output logic full
);

  req_t                 entry_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_AW:0]     count_r, count_nxt;

  assign empty = (count_r == '0);
  assign full  = (count_r == (FIFO_AW+1)'(FIFO_DEPTH));
  assign head  = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == FIFO_AW'(FIFO_DEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == FIFO_AW'(FIFO_DEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_req;
    end
  end

  `MCG_ASSERT_IMP(a_no_overflow, push, !full || pop)
  `MCG_ASSERT_IMP(a_no_underflow, pop, !empty)
  `MCG_ASSERT_IMP(a_count_bound, 1'b1, count_r <= (FIFO_AW+1)'(FIFO_DEPTH))

endmodule

// ----- rtl/core/mcg_back.sv -----
`include "midpoint_circle_generator_macros.svh"

module mcg_back
  import mcg_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  req_t        head,
  input  logic        empty,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_center_x,
  output logic [7:0]  out_center_y,
  output logic [5:0]  out_offset_a,
  output logic [5:0]  out_offset_b,
  output logic [7:0]  out_visible_mask,
  output logic [15:0] out_pixel_color,
  output logic        out_last
);

  back_state_t           state_r, state_nxt;
  logic [7:0]            cx_r, cy_r;
  logic [15:0]           color_r;
  logic [5:0]            a_r, b_r;
  logic signed [D_W-1:0] d_r;

  logic [5:0]            a_nxt, b_nxt;
  logic signed [D_W-1:0] d_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [7:0]            ocx_r, ocy_r, mask_r;
  logic [5:0]            oa_r, ob_r;
  logic [15:0]           ocol_r;
  logic                  olast_r;

  logic                  slot_free, step, load, diag, last;
  logic signed [D_W-1:0] a_s, b_s;
  logic [7:0]            a_adv;

  assign slot_free = !out_valid_r || out_ready;
  assign step      = (state_r == ST_RUN) && slot_free;
  assign load      = (state_r == ST_IDLE) && !empty;
  assign pop       = load;

  assign a_s  = $signed({{(D_W-6){1'b0}}, a_r});
  assign b_s  = $signed({{(D_W-6){1'b0}}, b_r});
  assign diag = !d_r[D_W-1];

  // a+1 > b' with b' = b-1 on a diagonal step
  assign a_adv = {2'b00, a_r} + (diag ? 8'd2 : 8'd1);
  assign last  = (a_adv > {2'b00, b_r}) || (a_r == 6'(RESULT_CAP-1));

  always_comb begin
    state_nxt = state_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    d_nxt     = d_r;
    unique case (state_r)
      ST_IDLE: begin
        if (load) begin
          a_nxt     = '0;
          b_nxt     = head.radius;
          d_nxt     = D_W'(3) - $signed({{(D_W-7){1'b0}}, head.radius, 1'b0});
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (step) begin
          a_nxt = a_r + 1'b1;
          if (diag) begin
            d_nxt = d_r + ((a_s - b_s) <<< 2) + D_W'(10);
            b_nxt = b_r - 1'b1;
          end else begin
            d_nxt = d_r + (a_s <<< 2) + D_W'(6);
          end
          if (last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (step) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r <= a_nxt;
    b_r <= b_nxt;
    d_r <= d_nxt;
    if (load) begin
      cx_r    <= head.center_x;
      cy_r    <= head.center_y;
      color_r <= head.color;
    end
    if (step) begin
      ocx_r   <= cx_r;
      ocy_r   <= cy_r;
      oa_r    <= a_r;
      ob_r    <= b_r;
      mask_r  <= octant_mask(cx_r, cy_r, a_r, b_r);
      ocol_r  <= color_r;
      olast_r <= last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_center_x     = ocx_r;
  assign out_center_y     = ocy_r;
  assign out_offset_a     = oa_r;
  assign out_offset_b     = ob_r;
  assign out_visible_mask = mask_r;
  assign out_pixel_color  = ocol_r;
  assign out_last         = olast_r;

  `MCG_ASSERT_NXT(a_load_runs, load, state_r == ST_RUN)
  `MCG_ASSERT_IMP(a_run_in_range, state_r == ST_RUN, a_r <= b_r)
  `MCG_ASSERT_NXT(a_last_idles, step && last, state_r == ST_IDLE && out_last)

endmodule

// ----- rtl/core/midpoint_circle_generator.sv -----
// Channel  | Direction | Handshake             | Payload
// in       | input     | in_valid / in_ready   | center_x, center_y, radius, color
// out      | output    | out_valid / out_ready | center, offsets a/b, mask, color, last
//
// Each drawn circle is loaded from the queue, then gives one result per cycle while
// a <= b and no result is stalled: about floor(r/sqrt(2)) + 1 results, 45 for radius
// 63. The single midpoint stepping unit in the back end takes the next circle only
// after the last result of the one before; a stalled result holds the stepping unit
// until it is taken. Items whose center is off screen are taken and give nothing.
// rst_n is synchronous and active low; it empties the queue and the output stage.
module midpoint_circle_generator
  import mcg_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_center_x,
  input  logic [7:0]  in_center_y,
  input  logic [5:0]  in_radius,
  input  logic [15:0] in_color,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_center_x,
  output logic [7:0]  out_center_y,
  output logic [5:0]  out_offset_a,
  output logic [5:0]  out_offset_b,
  output logic [7:0]  out_visible_mask,
  output logic [15:0] out_pixel_color,
  output logic        out_last
);

  logic push, pop, empty, full;
  req_t push_req, head;

  mcg_front u_front (
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_center_x (in_center_x),
    .in_center_y (in_center_y),
    .in_radius   (in_radius),
    .in_color    (in_color),
    .fifo_full   (full),
    .push        (push),
    .push_req    (push_req)
  );

  mcg_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_req (push_req),
    .pop      (pop),
    .head     (head),
    .empty    (empty),
    .full     (full)
  );

  mcg_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head             (head),
    .empty            (empty),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_center_x     (out_center_x),
    .out_center_y     (out_center_y),
    .out_offset_a     (out_offset_a),
    .out_offset_b     (out_offset_b),
    .out_visible_mask (out_visible_mask),
    .out_pixel_color  (out_pixel_color),
    .out_last         (out_last)
  );

endmodule

// ----- tb/midpoint_circle_generator_tb.sv -----
`timescale 1ns / 1ps

module midpoint_circle_generator_tb;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int DRAIN_CYCLES = 60;
  localparam int RANDOM_ITEMS = 427;

  typedef struct {
    logic [7:0]  cx;
    logic [7:0]  cy;
    logic [5:0]  a;
    logic [5:0]  b;
    logic [7:0]  mask;
    logic [15:0] color;
    logic        last;
  } arc_pt_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_center_x = '0;
  logic [7:0]  in_center_y = '0;
  logic [5:0]  in_radius = '0;
  logic [15:0] in_color = '0;
  logic        out_valid;
  logic        out_ready = 1'b1;
  logic [7:0]  out_center_x;
  logic [7:0]  out_center_y;
  logic [5:0]  out_offset_a;
  logic [5:0]  out_offset_b;
  logic [7:0]  out_visible_mask;
  logic [15:0] out_pixel_color;
  logic        out_last;

  arc_pt_t     arc_q[$];
  bit          steady = 1'b0;
  int unsigned sink_hold = 0;
  int unsigned sink_draw;
  int unsigned cycle_cnt = 0;
  int unsigned errors = 0;
  int unsigned items_sent = 0;
  int unsigned offscreen_sent = 0;
  int unsigned pts_checked = 0;

  midpoint_circle_generator uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_center_x      (in_center_x),
    .in_center_y      (in_center_y),
    .in_radius        (in_radius),
    .in_color         (in_color),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_center_x     (out_center_x),
    .out_center_y     (out_center_y),
    .out_offset_a     (out_offset_a),
    .out_offset_b     (out_offset_b),
    .out_visible_mask (out_visible_mask),
    .out_pixel_color  (out_pixel_color),
    .out_last         (out_last)
  );

  always #1 clk = ~clk;

  function automatic int unsigned draw_wait();
    if (steady) return 0;
    return $urandom_range(0, 6);
  endfunction

  function automatic logic pixel_visible(input int px, input int py);
    return px >= 0 && px < mcg_pkg::SCREEN_WIDTH && py >= 0 && py < mcg_pkg::SCREEN_HEIGHT;
  endfunction

  // expected octant points of one circle, appended in emit order
  function automatic void predict_circle(input logic [7:0] cx, input logic [7:0] cy,
                                         input logic [5:0] r, input logic [15:0] color);
    int x, y, a, b, d, n;
    arc_pt_t p;
    x = cx;
    y = cy;
    if (x >= mcg_pkg::SCREEN_WIDTH || y >= mcg_pkg::SCREEN_HEIGHT) return;
    b = r;
    if (b > mcg_pkg::MAX_RADIUS) b = mcg_pkg::MAX_RADIUS;
    a = 0;
    d = 3 - 2 * b;
    n = 0;
    while (a <= b && n < mcg_pkg::RESULT_CAP) begin
      p.cx = cx;
      p.cy = cy;
      p.a = 6'(a);
      p.b = 6'(b);
      p.color = color;
      p.mask = {pixel_visible(x - b, y - a), pixel_visible(x - b, y + a),
                pixel_visible(x + b, y - a), pixel_visible(x + b, y + a),
                pixel_visible(x - a, y - b), pixel_visible(x - a, y + b),
                pixel_visible(x + a, y - b), pixel_visible(x + a, y + b)};
      if (d < 0) begin
        d += 4 * a + 6;
      end else begin
        d += 4 * (a - b) + 10;
        b--;
      end
      a++;
      n++;
      p.last = (a > b) || (n >= mcg_pkg::RESULT_CAP);
      arc_q.push_back(p);
    end
  endfunction

  task automatic send_circle(input logic [7:0] cx, input logic [7:0] cy,
                             input logic [5:0] r, input logic [15:0] color);
    int unsigned gap;
    gap = draw_wait();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_center_x <= cx;
    in_center_y <= cy;
    in_radius <= r;
    in_color <= color;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_circle(cx, cy, r, color);
    items_sent++;
    if (cx >= mcg_pkg::SCREEN_WIDTH || cy >= mcg_pkg::SCREEN_HEIGHT) offscreen_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (arc_q.size() != 0) @(posedge clk);
  endtask

  task automatic send_random_circle();
    logic [7:0] cx, cy;
    logic [5:0] r;
    // mostly drawable circles, some with any center to hit the reject path
    if ($urandom_range(0, 3) != 0) begin
      cx = 8'($urandom_range(0, mcg_pkg::SCREEN_WIDTH - 1));
      cy = 8'($urandom_range(0, mcg_pkg::SCREEN_HEIGHT - 1));
    end else begin
      cx = 8'($urandom_range(0, 255));
      cy = 8'($urandom_range(0, 255));
    end
    r = 6'($urandom_range(0, 1) ? $urandom_range(0, 15) : $urandom_range(0, 63));
    send_circle(cx, cy, r, 16'($urandom_range(0, 16'hffff)));
  endtask

  task automatic test_corners();
    send_circle(8'd0, 8'd0, 6'd0, 16'h0000);
    send_circle(8'd95, 8'd63, 6'd0, 16'hffff);
    send_circle(8'd0, 8'd0, 6'd63, 16'hffff);
    send_circle(8'd95, 8'd63, 6'd63, 16'h0000);
    send_circle(8'd48, 8'd32, 6'd63, 16'ha5a5);
    send_circle(8'd48, 8'd32, 6'd1, 16'h5a5a);
    send_circle(8'd95, 8'd0, 6'd20, 16'h1234);
  endtask

  task automatic test_offscreen();
    send_circle(8'd96, 8'd0, 6'd10, 16'hffff);
    send_circle(8'd0, 8'd64, 6'd10, 16'h0001);
    send_circle(8'd255, 8'd255, 6'd63, 16'hffff);
    send_circle(8'd200, 8'd10, 6'd5, 16'h8000);
    send_circle(8'd95, 8'd64, 6'd0, 16'h00ff);
    // drawable item right behind a run of rejects
    send_circle(8'd0, 8'd63, 6'd5, 16'hff00);
  endtask

  task automatic test_back_to_back();
    steady = 1'b1;
    repeat (20) send_random_circle();
    wait_drained();
    steady = 1'b0;
  endtask

  task automatic test_pause();
    send_circle(8'd10, 8'd10, 6'd12, 16'hbeef);
    wait_drained();
    send_circle(8'd60, 8'd40, 6'd30, 16'hcafe);
  endtask

  task automatic test_random();
    repeat (RANDOM_ITEMS) send_random_circle();
  endtask

  // result sink: random stall after each accepted item
  always @(posedge clk) begin
    if (sink_hold != 0) begin
      sink_hold <= sink_hold - 1;
      if (sink_hold == 1) out_ready <= 1'b1;
    end else if (out_valid && out_ready) begin
      sink_draw = draw_wait();
      if (sink_draw != 0) begin
        out_ready <= 1'b0;
        sink_hold <= sink_draw;
      end
    end
  end

  always @(posedge clk) begin
    arc_pt_t e;
    if (rst_n && out_valid && out_ready) begin
      pts_checked++;
      if (arc_q.size() == 0) begin
        $error("unexpected result: a=%0d b=%0d", out_offset_a, out_offset_b);
        errors++;
      end else begin
        e = arc_q.pop_front();
        if (out_center_x !== e.cx) begin
          $error("out_center_x: expected %0d, got %0d", e.cx, out_center_x);
          errors++;
        end
        if (out_center_y !== e.cy) begin
          $error("out_center_y: expected %0d, got %0d", e.cy, out_center_y);
          errors++;
        end
        if (out_offset_a !== e.a) begin
          $error("offset_a: expected %0d, got %0d", e.a, out_offset_a);
          errors++;
        end
        if (out_offset_b !== e.b) begin
          $error("offset_b: expected %0d, got %0d", e.b, out_offset_b);
          errors++;
        end
        if (out_visible_mask !== e.mask) begin
          $error("visible_mask: expected %b, got %b", e.mask, out_visible_mask);
          errors++;
        end
        if (out_pixel_color !== e.color) begin
          $error("pixel_color: expected %h, got %h", e.color, out_pixel_color);
          errors++;
        end
        if (out_last !== e.last) begin
          $error("last: expected %b, got %b", e.last, out_last);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout with %0d results outstanding", arc_q.size());
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_corners();
    test_offscreen();
    test_back_to_back();
    test_pause();
    test_random();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (arc_q.size() != 0) begin
      $error("%0d expected results never arrived", arc_q.size());
      errors++;
    end
    $display("Sent %0d circle requests (%0d with off-screen centers), checked %0d points.",
             items_sent, offscreen_sent, pts_checked);
    $display("Covered screen corners, radius 0 and 63, rejects, back-to-back and random stalls.");
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- midpoint_circle_generator.f -----
+incdir+rtl/core
rtl/core/mcg_pkg.sv
rtl/core/mcg_front.sv
rtl/core/mcg_fifo.sv
rtl/core/mcg_back.sv
rtl/core/midpoint_circle_generator.sv
tb/midpoint_circle_generator_tb.sv
